// ===== sv/cvbs_pkg.sv =====
// Package for the cell voltage balance selector: field widths, derived
// datapath widths, register indexes, reset values and shared types.
// No dependencies; every other file of the block refers to it.
package cvbs_pkg;

  // Cell count: storage limit and default number of active lanes.
  localparam int unsigned MAX_CELLS = 5;
  localparam int unsigned CELLS_DEF = 5;

  // Field widths.
  localparam int unsigned CODE_W  = 14;
  localparam int unsigned GAIN_W  = 9;
  localparam int unsigned OFF_W   = 8;
  localparam int unsigned DELTA_W = 10;
  localparam int unsigned FLOOR_W = 13;
  localparam int unsigned TEMP_W  = 8;
  localparam int unsigned UV_W    = 24;
  localparam int unsigned MASK_W  = MAX_CELLS;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Millivolt to microvolt scale.
  localparam int unsigned MV_TO_UV = 1000;

  // Derived widths of the microvolt datapath.
  localparam int unsigned PROD_W     = GAIN_W + CODE_W;   // gain * code, unsigned
  localparam int unsigned V_W        = PROD_W + 2;        // cell voltage, signed
  localparam int unsigned DIFF_W     = V_W + 1;           // voltage minus minimum
  localparam int unsigned OFF_UV_W   = 18;                // offset in uV, signed
  localparam int unsigned DELTA_UV_W = 20;                // delta in uV
  localparam int unsigned FLOOR_UV_W = 23;                // floor in uV

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_UV          = 3'd0,
    REG_OFFSET_MV        = 3'd1,
    REG_BALANCE_DELTA_MV = 3'd2,
    REG_BALANCE_FLOOR_MV = 3'd3,
    REG_TEMP_MIN_C       = 3'd4,
    REG_TEMP_MAX_C       = 3'd5
  } reg_idx_t;

  // Reset values, already scaled where the datapath keeps microvolts.
  localparam logic [GAIN_W-1:0]            GAIN_RST     = 9'd365;
  localparam logic signed [OFF_UV_W-1:0]   OFF_UV_RST   = 18'sd0;
  localparam logic [DELTA_UV_W-1:0]        DELTA_UV_RST = 20'd50000;
  localparam logic [FLOOR_UV_W-1:0]        FLOOR_UV_RST = 23'd3300000;
  localparam logic signed [TEMP_W-1:0]     TMIN_RST     = 8'sd0;
  localparam logic signed [TEMP_W-1:0]     TMAX_RST     = 8'sd40;

  typedef logic signed [V_W-1:0]  v_t;
  typedef logic signed [UV_W-1:0] uv_t;

  // Configuration as held by the datapath.
  typedef struct packed {
    logic [GAIN_W-1:0]          gain;
    logic signed [OFF_UV_W-1:0] off_uv;
    logic [DELTA_UV_W-1:0]      delta_uv;
    logic [FLOOR_UV_W-1:0]      floor_uv;
    logic signed [TEMP_W-1:0]   temp_min;
    logic signed [TEMP_W-1:0]   temp_max;
  } cfg_t;

endpackage

// ===== sv/cvbs_in_if.sv =====
// Input channel of the cell voltage balance selector: five ADC codes and
// the pack temperature with a valid/ready handshake. Depends on cvbs_pkg.
interface cvbs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [cvbs_pkg::CODE_W-1:0]          cell0_code;
  logic [cvbs_pkg::CODE_W-1:0]          cell1_code;
  logic [cvbs_pkg::CODE_W-1:0]          cell2_code;
  logic [cvbs_pkg::CODE_W-1:0]          cell3_code;
  logic [cvbs_pkg::CODE_W-1:0]          cell4_code;
  logic signed [cvbs_pkg::TEMP_W-1:0]   pack_temp_c;

  modport source (output valid, cell0_code, cell1_code, cell2_code, cell3_code,
                  cell4_code, pack_temp_c, input ready);
  modport sink   (input valid, cell0_code, cell1_code, cell2_code, cell3_code,
                  cell4_code, pack_temp_c, output ready);
endinterface

// ===== sv/cvbs_out_if.sv =====
// Result channel of the cell voltage balance selector: five cell voltages
// and the bleed mask with a valid/ready handshake. Depends on cvbs_pkg.
interface cvbs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [cvbs_pkg::UV_W-1:0]   cell0_uv;
  logic signed [cvbs_pkg::UV_W-1:0]   cell1_uv;
  logic signed [cvbs_pkg::UV_W-1:0]   cell2_uv;
  logic signed [cvbs_pkg::UV_W-1:0]   cell3_uv;
  logic signed [cvbs_pkg::UV_W-1:0]   cell4_uv;
  logic [cvbs_pkg::MASK_W-1:0]        balance_mask;

  modport source (output valid, cell0_uv, cell1_uv, cell2_uv, cell3_uv, cell4_uv,
                  balance_mask, input ready);
  modport sink   (input valid, cell0_uv, cell1_uv, cell2_uv, cell3_uv, cell4_uv,
                  balance_mask, output ready);
endinterface

// ===== sv/cvbs_cfg_if.sv =====
// Configuration write channel of the cell voltage balance selector:
// register index and write data with a valid/ready handshake. Depends on cvbs_pkg.
interface cvbs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cvbs_pkg::CFG_IDX_W-1:0]    idx;
  logic [cvbs_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

// ===== sv/cvbs_lane.sv =====
// One cell lane: converts a raw ADC code into microvolts and registers it.
// Depends on cvbs_pkg.
module cvbs_lane (
  input  logic                                   clk,
  input  logic                                   adv,
  input  logic [cvbs_pkg::GAIN_W-1:0]            gain,
  input  logic signed [cvbs_pkg::OFF_UV_W-1:0]   off_uv,
  input  logic [cvbs_pkg::CODE_W-1:0]            code,
  output cvbs_pkg::v_t                           v
);

  logic [cvbs_pkg::PROD_W-1:0] prod;
  cvbs_pkg::v_t                v_nxt;
  cvbs_pkg::v_t                v_r;

  // The product is unsigned; a zero on top makes it a positive signed value.
  assign prod  = cvbs_pkg::PROD_W'(gain) * cvbs_pkg::PROD_W'(code);
  assign v_nxt = cvbs_pkg::V_W'($signed({1'b0, prod})) + cvbs_pkg::V_W'(off_uv);

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r <= v_nxt;
    end
  end

  assign v = v_r;

endmodule

// ===== sv/cvbs_min.sv =====
// Merge stage that finds the lowest active cell voltage and carries the
// lane voltages and temperature flag along. Depends on cvbs_pkg.
module cvbs_min #(
  parameter int unsigned CELLS = cvbs_pkg::CELLS_DEF
) (
  input  logic         clk,
  input  logic         adv,
  input  cvbs_pkg::v_t v_in   [cvbs_pkg::MAX_CELLS],
  input  logic         temp_ok_in,
  output cvbs_pkg::v_t v_out  [cvbs_pkg::MAX_CELLS],
  output cvbs_pkg::v_t vmin,
  output logic         temp_ok_out
);

  cvbs_pkg::v_t vmin_nxt;
  cvbs_pkg::v_t vmin_r;
  cvbs_pkg::v_t v_r [cvbs_pkg::MAX_CELLS];
  logic         temp_ok_r;

  always_comb begin
    vmin_nxt = v_in[0];
    for (int i = 1; i < CELLS; i++) begin
      if (v_in[i] < vmin_nxt) begin
        vmin_nxt = v_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vmin_r    <= vmin_nxt;
      v_r       <= v_in;
      temp_ok_r <= temp_ok_in;
    end
  end

  assign vmin        = vmin_r;
  assign v_out       = v_r;
  assign temp_ok_out = temp_ok_r;

endmodule

// ===== sv/cvbs_select.sv =====
// Final stage: marks cells for bleeding, resolves adjacent marked pairs
// and registers the saturated voltages and the mask. Depends on cvbs_pkg.
module cvbs_select #(
  parameter int unsigned CELLS = cvbs_pkg::CELLS_DEF
) (
  input  logic                                 clk,
  input  logic                                 adv,
  input  cvbs_pkg::v_t                         v     [cvbs_pkg::MAX_CELLS],
  input  cvbs_pkg::v_t                         vmin,
  input  logic                                 temp_ok,
  input  logic [cvbs_pkg::DELTA_UV_W-1:0]      delta_uv,
  input  logic [cvbs_pkg::FLOOR_UV_W-1:0]      floor_uv,
  output cvbs_pkg::uv_t                        uv    [cvbs_pkg::MAX_CELLS],
  output logic [cvbs_pkg::MASK_W-1:0]          mask
);

  localparam int unsigned V_W  = cvbs_pkg::V_W;
  localparam int unsigned UV_W = cvbs_pkg::UV_W;

  // Clamp a wide voltage into the output field.
  function automatic cvbs_pkg::uv_t sat_uv(input cvbs_pkg::v_t x);
    logic over;
    over = (x[V_W-1] != x[UV_W-1]);
    if (!over) begin
      sat_uv = x[UV_W-1:0];
    end else if (x[V_W-1]) begin
      sat_uv = {1'b1, {(UV_W-1){1'b0}}};
    end else begin
      sat_uv = {1'b0, {(UV_W-1){1'b1}}};
    end
  endfunction

  logic signed [cvbs_pkg::DIFF_W-1:0] delta_s;
  cvbs_pkg::v_t                       floor_s;
  logic [cvbs_pkg::MASK_W-1:0]        mark;
  logic [cvbs_pkg::MASK_W-1:0]        mask_nxt;
  logic [cvbs_pkg::MASK_W-1:0]        ge;
  cvbs_pkg::uv_t                      uv_nxt [cvbs_pkg::MAX_CELLS];
  cvbs_pkg::uv_t                      uv_r   [cvbs_pkg::MAX_CELLS];
  logic [cvbs_pkg::MASK_W-1:0]        mask_r;

  assign delta_s = cvbs_pkg::DIFF_W'($signed({1'b0, delta_uv}));
  assign floor_s = cvbs_pkg::V_W'($signed({1'b0, floor_uv}));

  // Per-lane marking and the greater-or-equal comparison used by the pair pass.
  always_comb begin
    mark = '0;
    ge   = '0;
    for (int i = 0; i < CELLS; i++) begin
      mark[i] = temp_ok && (v[i] > floor_s)
                && ((cvbs_pkg::DIFF_W'(v[i]) - cvbs_pkg::DIFF_W'(vmin)) >= delta_s);
    end
    for (int i = 0; i + 1 < CELLS; i++) begin
      ge[i] = (v[i] >= v[i+1]);
    end
  end

  // Pair pass from the bottom cell upward; an earlier pair can clear a mark
  // that the next pair would otherwise see.
  always_comb begin
    mask_nxt = mark;
    for (int i = 0; i + 1 < CELLS; i++) begin
      if (mask_nxt[i] && mask_nxt[i+1]) begin
        if (ge[i]) begin
          mask_nxt[i+1] = 1'b0;
        end else begin
          mask_nxt[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < cvbs_pkg::MAX_CELLS; i++) begin
      uv_nxt[i] = (i < CELLS) ? sat_uv(v[i]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      uv_r   <= uv_nxt;
      mask_r <= mask_nxt;
    end
  end

  assign uv   = uv_r;
  assign mask = mask_r;

endmodule

// ===== sv/cell_voltage_balance_select_core.sv =====
// Top level of the cell voltage balance selector: configuration registers,
// handshake control and the three pipeline stages. Depends on cvbs_pkg,
// the three channel interfaces, cvbs_lane, cvbs_min and cvbs_select.
//
//   Channel   Direction  Transaction carries
//   in_if     sink       cell0..cell4 ADC codes, pack temperature
//   out_if    source     cell0..cell4 voltages in uV, balance mask
//   cfg_if    sink       register index, write data
//
// An item passes three registered stages to a valid result: the lane multiply
// and offset add, the minimum search across lanes, and the marking, pair
// resolution and saturation. One item is taken per cycle unless the output
// stalls. Reset (rst_n low, synchronous) empties the pipeline and loads the
// default configuration. A stalled result holds the output stage; earlier
// stages keep accepting transactions until every stage is full.
module cell_voltage_balance_select_core #(
  parameter int unsigned CELLS = cvbs_pkg::CELLS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  cvbs_in_if.sink  in_if,
  cvbs_out_if.source out_if,
  cvbs_cfg_if.sink cfg_if
);

  // Configuration registers. Scaled values are formed once at write time
  // so the datapath compares microvolts directly.
  cvbs_pkg::cfg_t cfg_r;
  cvbs_pkg::cfg_t cfg_nxt;
  logic signed [cvbs_pkg::OFF_W-1:0]      off_mv;
  logic signed [cvbs_pkg::OFF_UV_W-1:0]   mv_to_uv_s;

  assign cfg_if.ready = 1'b1;
  assign off_mv       = $signed(cfg_if.wdata[cvbs_pkg::OFF_W-1:0]);
  assign mv_to_uv_s   = cvbs_pkg::OFF_UV_W'(cvbs_pkg::MV_TO_UV);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cvbs_pkg::reg_idx_t'(cfg_if.idx))
        cvbs_pkg::REG_GAIN_UV: begin
          cfg_nxt.gain = cfg_if.wdata[cvbs_pkg::GAIN_W-1:0];
        end
        cvbs_pkg::REG_OFFSET_MV: begin
          cfg_nxt.off_uv = cvbs_pkg::OFF_UV_W'(off_mv) * mv_to_uv_s;
        end
        cvbs_pkg::REG_BALANCE_DELTA_MV: begin
          cfg_nxt.delta_uv = cvbs_pkg::DELTA_UV_W'(cfg_if.wdata[cvbs_pkg::DELTA_W-1:0])
                             * cvbs_pkg::DELTA_UV_W'(cvbs_pkg::MV_TO_UV);
        end
        cvbs_pkg::REG_BALANCE_FLOOR_MV: begin
          cfg_nxt.floor_uv = cvbs_pkg::FLOOR_UV_W'(cfg_if.wdata[cvbs_pkg::FLOOR_W-1:0])
                             * cvbs_pkg::FLOOR_UV_W'(cvbs_pkg::MV_TO_UV);
        end
        cvbs_pkg::REG_TEMP_MIN_C: begin
          cfg_nxt.temp_min = $signed(cfg_if.wdata[cvbs_pkg::TEMP_W-1:0]);
        end
        cvbs_pkg::REG_TEMP_MAX_C: begin
          cfg_nxt.temp_max = $signed(cfg_if.wdata[cvbs_pkg::TEMP_W-1:0]);
        end
        default: begin
          // Indexes past the register list are ignored.
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain     <= cvbs_pkg::GAIN_RST;
      cfg_r.off_uv   <= cvbs_pkg::OFF_UV_RST;
      cfg_r.delta_uv <= cvbs_pkg::DELTA_UV_RST;
      cfg_r.floor_uv <= cvbs_pkg::FLOOR_UV_RST;
      cfg_r.temp_min <= cvbs_pkg::TMIN_RST;
      cfg_r.temp_max <= cvbs_pkg::TMAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Pipeline occupancy. Each stage loads whenever it is empty or its
  // contents move on in the same cycle, so bubbles close up under a stall.
  logic s1_vld_r, s1_vld_nxt;
  logic s2_vld_r, s2_vld_nxt;
  logic s3_vld_r, s3_vld_nxt;
  logic s1_adv, s2_adv, s3_adv;

  assign s3_adv = !s3_vld_r || out_if.ready;
  assign s2_adv = !s2_vld_r || s3_adv;
  assign s1_adv = !s1_vld_r || s2_adv;

  assign s1_vld_nxt = s1_adv ? in_if.valid : s1_vld_r;
  assign s2_vld_nxt = s2_adv ? s1_vld_r    : s2_vld_r;
  assign s3_vld_nxt = s3_adv ? s2_vld_r    : s3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
      s3_vld_r <= s3_vld_nxt;
    end
  end

  assign in_if.ready  = s1_adv;
  assign out_if.valid = s3_vld_r;

  // Stage 1: one lane per active cell, plus the temperature window check.
  logic [cvbs_pkg::CODE_W-1:0] codes [cvbs_pkg::MAX_CELLS];
  cvbs_pkg::v_t                s1_v  [cvbs_pkg::MAX_CELLS];
  logic                        temp_ok_nxt;
  logic                        s1_temp_ok_r;

  assign codes[0] = in_if.cell0_code;
  assign codes[1] = in_if.cell1_code;
  assign codes[2] = in_if.cell2_code;
  assign codes[3] = in_if.cell3_code;
  assign codes[4] = in_if.cell4_code;

  // An empty window (minimum above maximum) fails at least one compare for any value.
  assign temp_ok_nxt = (in_if.pack_temp_c >= cfg_r.temp_min)
                       && (in_if.pack_temp_c <= cfg_r.temp_max);

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_temp_ok_r <= temp_ok_nxt;
    end
  end

  for (genvar g = 0; g < cvbs_pkg::MAX_CELLS; g++) begin : g_lane
    if (g < CELLS) begin : g_on
      cvbs_lane u_lane (
        .clk    (clk),
        .adv    (s1_adv),
        .gain   (cfg_r.gain),
        .off_uv (cfg_r.off_uv),
        .code   (codes[g]),
        .v      (s1_v[g])
      );
    end else begin : g_off
      // Inactive cells carry zero and are ignored downstream.
      assign s1_v[g] = '0;
    end
  end

  // Stage 2: minimum across the active lanes.
  cvbs_pkg::v_t s2_v [cvbs_pkg::MAX_CELLS];
  cvbs_pkg::v_t s2_vmin;
  logic         s2_temp_ok;

  cvbs_min #(.CELLS(CELLS)) u_min (
    .clk         (clk),
    .adv         (s2_adv),
    .v_in        (s1_v),
    .temp_ok_in  (s1_temp_ok_r),
    .v_out       (s2_v),
    .vmin        (s2_vmin),
    .temp_ok_out (s2_temp_ok)
  );

  // Stage 3: marking, adjacent pair resolution and the output register.
  cvbs_pkg::uv_t              s3_uv [cvbs_pkg::MAX_CELLS];
  logic [cvbs_pkg::MASK_W-1:0] s3_mask;

  cvbs_select #(.CELLS(CELLS)) u_select (
    .clk      (clk),
    .adv      (s3_adv),
    .v        (s2_v),
    .vmin     (s2_vmin),
    .temp_ok  (s2_temp_ok),
    .delta_uv (cfg_r.delta_uv),
    .floor_uv (cfg_r.floor_uv),
    .uv       (s3_uv),
    .mask     (s3_mask)
  );

  assign out_if.cell0_uv     = s3_uv[0];
  assign out_if.cell1_uv     = s3_uv[1];
  assign out_if.cell2_uv     = s3_uv[2];
  assign out_if.cell3_uv     = s3_uv[3];
  assign out_if.cell4_uv     = s3_uv[4];
  assign out_if.balance_mask = s3_mask;

`ifndef SYNTHESIS
  // The pair pass never leaves two neighboring bleed resistors switched on.
  a_no_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> ((out_if.balance_mask & (out_if.balance_mask >> 1)) == '0))
    else $error("adjacent cells both marked for bleeding");

  // Cells beyond the active count never bleed.
  a_inactive_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> ((out_if.balance_mask >> CELLS) == '0))
    else $error("inactive cell marked for bleeding");

  // With an empty temperature window no cell is marked.
  a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (cfg_r.temp_min > cfg_r.temp_max)) |-> (out_if.balance_mask == '0))
    else $error("cell marked with empty temperature window");

  // An empty first stage always takes a transaction.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_if.ready)
    else $error("input stalled with first stage empty");

  // An item accepted while the later stages are empty moves through stage two
  // into the output stage, whatever the receiver does.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && !s2_vld_r && !s3_vld_r) |=> ##2 s3_vld_r)
    else $error("item lost between stages");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for cell_voltage_balance_select_core: drives ADC samples and
// register writes, predicts cell voltages and the bleed mask, and scores every result.
// Depends on cvbs_pkg, the three channel interfaces and the core itself.
module testbench;
  import cvbs_pkg::*;

  // The core is built with its default lane count, and the prediction follows it.
  localparam int unsigned ACTIVE_CELLS = CELLS_DEF;

  // The configuration port decodes three index bits but maps only six registers.
  // The two indexes above the list must be ignored by the core.
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

  // Saturation limits of a 24-bit signed voltage field.
  localparam longint UV_FIELD_MAX = 64'sd8388607;
  localparam longint UV_FIELD_MIN = -64'sd8388608;

  localparam int CODE_MAX = 16383;
  localparam int MAX_REPORTS = 30;

  // Run limit in time units. The slowest legal run, with both sides idling half
  // of the time and one long receiver hold-off, needs far less than that.
  localparam int RUN_LIMIT = 2_000_000;

  // One input transaction: five raw ADC codes and the pack temperature.
  typedef struct packed {
    logic [MAX_CELLS-1:0][CODE_W-1:0] code;
    logic signed [TEMP_W-1:0]         temp_c;
  } cell_sample_t;

  // One result transaction: five cell voltages and the bleed mask.
  typedef struct packed {
    logic [MAX_CELLS-1:0][UV_W-1:0] uv;
    logic [MASK_W-1:0]              mask;
  } readout_t;

  logic clk = 1'b0;
  logic rst_n;

  cvbs_in_if  in_ch ();
  cvbs_out_if out_ch ();
  cvbs_cfg_if cfg_ch ();

  cell_voltage_balance_select_core #(
    .CELLS (ACTIVE_CELLS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Shadow copy of the trim and balancing registers, in the raw form in which the
  // configuration port writes them. The core keeps them scaled; we scale on use.
  logic [GAIN_W-1:0]        trim_gain;
  logic signed [OFF_W-1:0]  trim_offset_mv;
  logic [DELTA_W-1:0]       bal_delta_mv;
  logic [FLOOR_W-1:0]       bal_floor_mv;
  logic signed [TEMP_W-1:0] win_min_c;
  logic signed [TEMP_W-1:0] win_max_c;

  // Results that the core still owes us, oldest first.
  readout_t readout_queue [$];
  int       mismatches = 0;

  // Traffic shaping. The percentages are the chance per cycle that the sender
  // holds back or that the receiver deasserts ready. A test asks for a long
  // receiver hold-off by loading stall_request; the ready process counts it down.
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int          stall_request = 0;
  int          stall_left    = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // Works out the voltages and bleed mask for one sample under the current
  // register settings. All arithmetic is done at 64 bits so that comparisons
  // see the exact voltage; only the reported field is saturated to 24 bits.
  function automatic readout_t compute_balance(cell_sample_t s);
    longint volt [MAX_CELLS];
    bit     marked [MAX_CELLS];
    longint vmin;
    longint off_uv;
    longint delta_uv;
    longint floor_uv;
    longint clipped;
    bit     temp_in_window;
    readout_t r;
    off_uv   = longint'(trim_offset_mv) * 1000;
    delta_uv = longint'(bal_delta_mv) * 1000;
    floor_uv = longint'(bal_floor_mv) * 1000;
    // An inverted window (minimum above maximum) can never be satisfied.
    temp_in_window = ($signed(s.temp_c) >= win_min_c) && ($signed(s.temp_c) <= win_max_c);
    vmin = 0;
    r = '0;
    for (int i = 0; i < MAX_CELLS; i++) begin
      volt[i] = 0;
      marked[i] = 1'b0;
    end
    // Lanes at or above the active count stay at zero and never join the minimum.
    for (int i = 0; i < ACTIVE_CELLS; i++) begin
      volt[i] = longint'(trim_gain) * longint'(s.code[i]) + off_uv;
      if (i == 0 || volt[i] < vmin) vmin = volt[i];
    end
    for (int i = 0; i < ACTIVE_CELLS; i++)
      marked[i] = (volt[i] - vmin >= delta_uv) && (volt[i] > floor_uv) && temp_in_window;
    // Neighbors are never bled together. Walking upward, the weaker of a marked
    // pair is dropped; on equal voltage the upper cell gives way. A cell dropped
    // here no longer counts as marked for the next pair.
    for (int i = 0; i + 1 < ACTIVE_CELLS; i++) begin
      if (marked[i] && marked[i + 1]) begin
        if (volt[i] >= volt[i + 1]) marked[i + 1] = 1'b0;
        else marked[i] = 1'b0;
      end
    end
    for (int i = 0; i < ACTIVE_CELLS; i++) begin
      clipped = volt[i];
      if (clipped > UV_FIELD_MAX) clipped = UV_FIELD_MAX;
      if (clipped < UV_FIELD_MIN) clipped = UV_FIELD_MIN;
      r.uv[i]   = clipped[UV_W-1:0];
      r.mask[i] = marked[i];
    end
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------

  function automatic void flag_mismatch(string field, longint want, longint got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endfunction

  // Every result transaction is scored against the oldest prediction. Both
  // valid and ready are sampled at the edge, before any update of that edge.
  always @(posedge clk) begin : score_readouts
    readout_t                       want;
    logic [MAX_CELLS-1:0][UV_W-1:0] got_uv;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got_uv = {out_ch.cell4_uv, out_ch.cell3_uv, out_ch.cell2_uv,
                out_ch.cell1_uv, out_ch.cell0_uv};
      if (readout_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result transaction with no prediction waiting, mask %b",
                   $time, out_ch.balance_mask);
      end else begin
        want = readout_queue.pop_front();
        for (int i = 0; i < MAX_CELLS; i++)
          if (got_uv[i] !== want.uv[i])
            flag_mismatch($sformatf("cell%0d_uv", i), $signed(want.uv[i]),
                          $signed(got_uv[i]));
        if (out_ch.balance_mask !== want.mask)
          flag_mismatch("balance_mask", want.mask, out_ch.balance_mask);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Receiver: random ready, with an optional long hold-off counted here.
  // ------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // Sender and register writer
  // ------------------------------------------------------------------------

  // Offers one sample and returns at the edge where it was taken. Valid is left
  // high so that back-to-back samples never lower and raise it in one step; the
  // next call or stop_offering decides what it does next.
  task automatic offer_sample(cell_sample_t s);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cell0_code  <= s.code[0];
    in_ch.cell1_code  <= s.code[1];
    in_ch.cell2_code  <= s.code[2];
    in_ch.cell3_code  <= s.code[3];
    in_ch.cell4_code  <= s.code[4];
    in_ch.pack_temp_c <= s.temp_c;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    readout_queue.push_back(compute_balance(s));
  endtask

  task automatic stop_offering();
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain_readouts();
    while (readout_queue.size() != 0) @(posedge clk);
  endtask

  // One register write transaction; the shadow copy takes the same bits the
  // core keeps. Indexes past the register list leave everything unchanged.
  task automatic set_register(logic [CFG_IDX_W-1:0] idx, int value);
    logic [CFG_DATA_W-1:0] wdata;
    wdata = value[CFG_DATA_W-1:0];
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.wdata <= wdata;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_GAIN_UV:          trim_gain      = wdata[GAIN_W-1:0];
      REG_OFFSET_MV:        trim_offset_mv = wdata[OFF_W-1:0];
      REG_BALANCE_DELTA_MV: bal_delta_mv   = wdata[DELTA_W-1:0];
      REG_BALANCE_FLOOR_MV: bal_floor_mv   = wdata[FLOOR_W-1:0];
      REG_TEMP_MIN_C:       win_min_c      = wdata[TEMP_W-1:0];
      REG_TEMP_MAX_C:       win_max_c      = wdata[TEMP_W-1:0];
      default: ;
    endcase
  endtask

  // Rewrites all six registers, but only once the core is idle: input stopped
  // and every predicted result delivered. Every sample produces a result, so an
  // empty queue means nothing is left in flight.
  task automatic apply_settings(int gain, int offset_mv, int delta_mv, int floor_mv,
                                int tmin_c, int tmax_c);
    stop_offering();
    drain_readouts();
    set_register(REG_GAIN_UV, gain);
    set_register(REG_OFFSET_MV, offset_mv);
    set_register(REG_BALANCE_DELTA_MV, delta_mv);
    set_register(REG_BALANCE_FLOOR_MV, floor_mv);
    set_register(REG_TEMP_MIN_C, tmin_c);
    set_register(REG_TEMP_MAX_C, tmax_c);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly values within the trim ranges; now and then any gain the register
  // holds, and now and then an inverted temperature window.
  task automatic apply_random_settings();
    int gain;
    int t_lo;
    int t_hi;
    int swap;
    gain = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(365, 396);
    t_lo = int'($urandom_range(0, 255)) - 128;
    t_hi = int'($urandom_range(0, 255)) - 128;
    if ($urandom_range(0, 5) != 0 && t_lo > t_hi) begin
      swap = t_lo;
      t_lo = t_hi;
      t_hi = swap;
    end
    apply_settings(gain, int'($urandom_range(0, 255)) - 128, $urandom_range(0, 1000),
                   $urandom_range(0, 6000), t_lo, t_hi);
  endtask

  // ------------------------------------------------------------------------
  // Sample generation
  // ------------------------------------------------------------------------

  function automatic cell_sample_t make_sample(int c0, int c1, int c2, int c3, int c4,
                                               int temp_c);
    cell_sample_t s;
    s.code[0] = c0[CODE_W-1:0];
    s.code[1] = c1[CODE_W-1:0];
    s.code[2] = c2[CODE_W-1:0];
    s.code[3] = c3[CODE_W-1:0];
    s.code[4] = c4[CODE_W-1:0];
    s.temp_c  = temp_c[TEMP_W-1:0];
    return s;
  endfunction

  // Fully random codes would almost always put one cell far below the rest, so
  // most samples are a realistic pack instead: cells clustered within a few
  // balancing deltas of a base that often sits right at the floor, frequent
  // equal neighbors, and a temperature usually inside the window.
  function automatic cell_sample_t random_sample();
    cell_sample_t s;
    int span;
    int spread;
    int base;
    int c;
    int prev;
    span = (trim_gain == 0) ? 64 : (int'(bal_delta_mv) * 1000) / int'(trim_gain);
    spread = 3 * span + 8;
    if (spread > CODE_MAX) spread = CODE_MAX;
    if ($urandom_range(0, 9) < 2) begin
      for (int i = 0; i < MAX_CELLS; i++) s.code[i] = CODE_W'($urandom_range(0, CODE_MAX));
      s.temp_c = TEMP_W'($urandom_range(0, 255));
      return s;
    end
    if ($urandom_range(0, 1) == 1 || trim_gain == 0)
      base = $urandom_range(0, CODE_MAX);
    else
      base = (int'(bal_floor_mv) * 1000 - int'(trim_offset_mv) * 1000) / int'(trim_gain)
             - spread / 2;
    if (base < 0) base = 0;
    if (base > CODE_MAX) base = CODE_MAX;
    prev = base;
    for (int i = 0; i < MAX_CELLS; i++) begin
      c = base + int'($urandom_range(0, spread));
      if (i > 0 && $urandom_range(0, 3) == 0) c = prev;
      if (c > CODE_MAX) c = CODE_MAX;
      s.code[i] = c[CODE_W-1:0];
      prev = c;
    end
    if ($urandom_range(0, 4) != 0 && win_min_c <= win_max_c)
      c = int'(win_min_c) + int'($urandom_range(0, int'(win_max_c) - int'(win_min_c)));
    else
      c = $urandom_range(0, 255);
    s.temp_c = c[TEMP_W-1:0];
    return s;
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Runs on the reset configuration: 365 uV per code, no offset, 50 mV delta,
  // 3.3 V floor and a 0..40 C window. Covers empty and full-scale codes, the
  // window edges, isolated marks, equal and unequal neighbor pairs, and a
  // chain where a cleared cell no longer blocks its upper neighbor.
  task automatic test_reset_defaults();
    in_idle_pct   = 9;
    out_stall_pct = 9;
    offer_sample(make_sample(0, 0, 0, 0, 0, 0));
    offer_sample(make_sample(CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, 127));
    offer_sample(make_sample(CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, -128));
    offer_sample(make_sample(9000, CODE_MAX, 9000, CODE_MAX, 9000, 25));
    offer_sample(make_sample(9000, 12000, 12000, 9000, 9000, 0));
    offer_sample(make_sample(9000, 12000, 13000, 9000, 9000, 40));
    offer_sample(make_sample(9000, 14000, 13000, 12000, 9000, 20));
    offer_sample(make_sample(9000, 12000, 13000, 14000, 9000, 20));
    offer_sample(make_sample(CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, 0, 10));
    offer_sample(make_sample(9000, 12000, 9000, 9000, 9000, -1));
    offer_sample(make_sample(9000, 12000, 9000, 9000, 9000, 41));
    // Alternating bit patterns so that every code and temperature bit toggles.
    offer_sample(make_sample('h2AAA, 'h1555, 'h2AAA, 'h1555, 'h2AAA, 'h55));
    offer_sample(make_sample('h1555, 'h2AAA, 'h1555, 'h2AAA, 'h1555, -86));
    // Just over the delta, right around the floor.
    offer_sample(make_sample(9041, 9178, 9042, 9179, 9042, 30));
  endtask

  // Register extremes: saturated voltages, zero gain, inverted window, write
  // data wider than the register, the ends of every trim range, writes to the
  // unmapped indexes, and exact delta and floor boundaries.
  task automatic test_config_extremes();
    // Full-scale code at the largest gain overflows 24 bits; with zero delta all
    // equal cells are marked and the pair pass leaves every other one.
    apply_settings(511, 127, 0, 0, -128, 127);
    offer_sample(make_sample(CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, 0));
    offer_sample(make_sample(CODE_MAX, 0, CODE_MAX, 0, CODE_MAX, 127));
    // Zero gain makes every cell equal to the (negative) offset.
    apply_settings(0, -128, 1000, 0, -128, 127);
    offer_sample(make_sample(0, CODE_MAX, 5, 'h2AAA, 'h1555, -128));
    // All-ones write data: the core must keep only the register's own bits.
    // This also leaves the window inverted, so nothing may be marked.
    apply_settings(8191, 8191, 8191, 8191, 127, -128);
    offer_sample(make_sample(0, CODE_MAX, 0, CODE_MAX, 0, 0));
    offer_sample(make_sample(0, CODE_MAX, 0, CODE_MAX, 0, 127));
    // Top of every trim range.
    apply_settings(396, 127, 1000, 6000, -128, 127);
    offer_sample(make_sample(CODE_MAX, 0, CODE_MAX, CODE_MAX, 0, 127));
    // Bottom of every trim range.
    apply_settings(365, -128, 0, 0, -128, -128);
    offer_sample(make_sample(0, 0, 0, 0, 0, -128));
    offer_sample(make_sample(CODE_MAX, 0, 'h2AAA, 0, CODE_MAX, -128));
    // Writes past the register list must change nothing. They go in only once
    // the input is stopped and the core is empty.
    stop_offering();
    drain_readouts();
    set_register(IDX_UNMAPPED_LO, 'h1FFF);
    set_register(IDX_UNMAPPED_HI, 'h0AAA);
    cfg_ch.valid <= 1'b0;
    offer_sample(make_sample(CODE_MAX, 0, CODE_MAX, 100, CODE_MAX, -128));
    // At 400 uV per code the 50 mV delta is exactly 125 codes and the 3.3 V
    // floor is exactly code 8250, which is not above the floor.
    apply_settings(400, 0, 50, 3300, 0, 40);
    offer_sample(make_sample(8250, 8375, 8251, 8374, 8250, 0));
    offer_sample(make_sample(8200, 8325, 8200, 8200, 8250, 40));
  endtask

  // The bulk of the run: four traffic phases (no idling, sender idle about half
  // the time, receiver stalling about half the time, both lightly), each going
  // through four random register settings.
  task automatic test_random_phases();
    int unsigned idle_pct [4]  = '{0, 49, 0, 9};
    int unsigned stall_pct [4] = '{0, 0, 49, 9};
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 4; k++) begin
        apply_random_settings();
        in_idle_pct   = idle_pct[p];
        out_stall_pct = stall_pct[p];
        repeat (110) offer_sample(random_sample());
      end
    end
  endtask

  // The receiver holds ready low for a long stretch while samples keep coming,
  // so the pipeline fills and the core has to stall its input.
  task automatic test_backpressure();
    apply_settings(380, -20, 20, 3000, -20, 60);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    stall_request = 300;
    repeat (40) offer_sample(random_sample());
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cell0_code  = '0;
    in_ch.cell1_code  = '0;
    in_ch.cell2_code  = '0;
    in_ch.cell3_code  = '0;
    in_ch.cell4_code  = '0;
    in_ch.pack_temp_c = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.idx        = '0;
    cfg_ch.wdata      = '0;

    // Shadow registers start at the documented reset values.
    trim_gain      = 9'd365;
    trim_offset_mv = 8'sd0;
    bal_delta_mv   = 10'd50;
    bal_floor_mv   = 13'd3300;
    win_min_c      = 8'sd0;
    win_max_c      = 8'sd40;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_config_extremes();
    test_random_phases();
    test_backpressure();

    stop_offering();
    drain_readouts();
    // Run on for longer than the three-stage pipeline needs, to catch stray results.
    repeat (10) @(posedge clk);
    if (mismatches == 0 && readout_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  initial begin
    #(RUN_LIMIT);
    $display("%0t: run limit reached with %0d results outstanding", $time,
             readout_queue.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
